// File: design/btlpm_pkg.sv
// Shared types and constants for the binary trie longest-prefix-match engine.
package btlpm_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 8;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_BADLEN = 2'd2;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [PORT_W-1:0] port_in;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [PORT_W-1:0] port_out;
        logic [1:0]        status;
    } t_out;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LK,
        S_IN,
        S_ALLOC,
        S_LINK,
        S_MARK,
        S_CLR,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_LK,
        OP_WALK,
        OP_FULL,
        OP_ALLOC,
        OP_LINK,
        OP_MARK,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       len_bad;
        logic       child_zero;
        logic       depth_end;
        logic       rem_one;
        logic       pool_full;
        logic       out_free;
    } t_sts;

endpackage

// File: design/btlpm_ram.sv
// Generic simple dual-port RAM with registered read.
module btlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/btlpm_ctrl.sv
// Controller state machine for the trie engine.
module btlpm_ctrl
    import btlpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.load_out = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_START;
                    case (i_sts.func)
                        FUNC_CLEAR:  n_state = S_CLR;
                        FUNC_INSERT: n_state = i_sts.len_bad ? S_FIN : S_IN;
                        FUNC_LOOKUP: n_state = S_LK;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_LK: begin
                o_cmd.op = OP_LK;
                if (i_sts.depth_end || i_sts.child_zero) begin
                    n_state = S_FIN;
                end
            end
            S_IN: begin
                if (i_sts.child_zero) begin
                    if (i_sts.pool_full) begin
                        o_cmd.op = OP_FULL;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else begin
                    o_cmd.op = OP_WALK;
                    n_state  = i_sts.rem_one ? S_MARK : S_IN;
                end
            end
            S_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                n_state  = S_LINK;
            end
            S_LINK: begin
                o_cmd.op = OP_LINK;
                n_state  = i_sts.rem_one ? S_MARK : S_IN;
            end
            S_MARK: begin
                o_cmd.op = OP_MARK;
                n_state  = S_FIN;
            end
            S_CLR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// File: design/btlpm_dp.sv
// Datapath: walk registers, node memories, allocator and result register.
module btlpm_dp
    import btlpm_pkg::*;
#(
    parameter int NODES      = 4096,
    parameter int PORT_WIDTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int IW = $clog2(NODES);
    localparam int MW = PORT_WIDTH + 1;
    localparam logic [IW:0] NODES_W = (IW+1)'(NODES);

    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [LEN_W-1:0]      r_rem, n_rem;
    logic [LEN_W-1:0]      r_depth, n_depth;
    logic [PORT_WIDTH-1:0] r_pin, n_pin;
    logic [IW-1:0]         r_cur, n_cur;
    logic [IW:0]           r_nfree, n_nfree;
    logic                  r_hit, n_hit;
    logic [PORT_WIDTH-1:0] r_port, n_port;
    logic [1:0]            r_status, n_status;
    logic                  r_ovalid;
    t_out                  r_out;

    logic [IW-1:0] w_left_rd, w_right_rd, w_child, w_raddr, w_free_idx;
    logic [MW-1:0] w_mark_rd;
    logic          w_bit, w_len_bad, w_out_free;
    logic [15:0]   w_pin_ext, w_port_ext;

    logic          w_left_we, w_right_we, w_mark_we;
    logic [IW-1:0] w_left_wa, w_right_wa, w_mark_wa;
    logic [IW-1:0] w_left_wd, w_right_wd;
    logic [MW-1:0] w_mark_wd;

    assign w_bit      = r_addr[ADDR_W-1];
    assign w_child    = w_bit ? w_right_rd : w_left_rd;
    assign w_free_idx = r_nfree[IW-1:0];
    assign w_len_bad  = (i_in_data.prefix_len == '0) || (i_in_data.prefix_len > MAX_LEN);
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_pin_ext  = 16'(i_in_data.port_in);
    assign w_port_ext = 16'(r_port);

    assign o_sts.func       = i_in_data.func;
    assign o_sts.len_bad    = w_len_bad;
    assign o_sts.child_zero = (w_child == '0);
    assign o_sts.depth_end  = (r_depth == MAX_LEN);
    assign o_sts.rem_one    = (r_rem == LEN_W'(1));
    assign o_sts.pool_full  = (r_nfree >= NODES_W);
    assign o_sts.out_free   = w_out_free;

    always_comb begin
        case (i_cmd.op)
            OP_START:      w_raddr = '0;
            OP_LK, OP_WALK: w_raddr = w_child;
            OP_LINK:       w_raddr = w_free_idx;
            default:       w_raddr = r_cur;
        endcase
    end

    always_comb begin
        w_left_we  = 1'b0;
        w_right_we = 1'b0;
        w_mark_we  = 1'b0;
        w_left_wa  = r_cur;
        w_right_wa = r_cur;
        w_mark_wa  = r_cur;
        w_left_wd  = '0;
        w_right_wd = '0;
        w_mark_wd  = '0;
        case (i_cmd.op)
            OP_CLEAR: begin
                w_left_we  = 1'b1;
                w_right_we = 1'b1;
                w_mark_we  = 1'b1;
                w_left_wa  = '0;
                w_right_wa = '0;
                w_mark_wa  = '0;
            end
            OP_ALLOC: begin
                w_left_we  = 1'b1;
                w_right_we = 1'b1;
                w_mark_we  = 1'b1;
                w_left_wa  = w_free_idx;
                w_right_wa = w_free_idx;
                w_mark_wa  = w_free_idx;
            end
            OP_LINK: begin
                w_left_we  = !w_bit;
                w_right_we = w_bit;
                w_left_wd  = w_free_idx;
                w_right_wd = w_free_idx;
            end
            OP_MARK: begin
                w_mark_we = 1'b1;
                w_mark_wd = {1'b1, r_pin};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_addr   = r_addr;
        n_rem    = r_rem;
        n_depth  = r_depth;
        n_pin    = r_pin;
        n_cur    = r_cur;
        n_nfree  = r_nfree;
        n_hit    = r_hit;
        n_port   = r_port;
        n_status = r_status;
        case (i_cmd.op)
            OP_START: begin
                n_addr   = i_in_data.address;
                n_rem    = i_in_data.prefix_len;
                n_depth  = '0;
                n_pin    = w_pin_ext[PORT_WIDTH-1:0];
                n_cur    = '0;
                n_hit    = 1'b0;
                n_port   = '0;
                n_status = (i_in_data.func == FUNC_INSERT && w_len_bad) ?
                           STATUS_BADLEN : STATUS_OK;
            end
            OP_LK: begin
                if (w_mark_rd[PORT_WIDTH]) begin
                    n_hit  = 1'b1;
                    n_port = w_mark_rd[PORT_WIDTH-1:0];
                end
                n_cur   = w_child;
                n_depth = r_depth + LEN_W'(1);
                n_addr  = r_addr << 1;
            end
            OP_WALK: begin
                n_cur  = w_child;
                n_rem  = r_rem - LEN_W'(1);
                n_addr = r_addr << 1;
            end
            OP_FULL: begin
                n_status = STATUS_FULL;
            end
            OP_LINK: begin
                n_cur   = w_free_idx;
                n_nfree = r_nfree + (IW+1)'(1);
                n_rem   = r_rem - LEN_W'(1);
                n_addr  = r_addr << 1;
            end
            OP_CLEAR: begin
                n_nfree = (IW+1)'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfree  <= (IW+1)'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_nfree <= n_nfree;
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rem    <= n_rem;
        r_depth  <= n_depth;
        r_pin    <= n_pin;
        r_cur    <= n_cur;
        r_hit    <= n_hit;
        r_port   <= n_port;
        r_status <= n_status;
        if (i_cmd.load_out) begin
            r_out.found    <= r_hit;
            r_out.port_out <= w_port_ext[PORT_W-1:0];
            r_out.status   <= r_status;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    btlpm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_left (
        .i_clk   (i_clk),
        .i_we    (w_left_we),
        .i_waddr (w_left_wa),
        .i_wdata (w_left_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_left_rd)
    );

    btlpm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_right (
        .i_clk   (i_clk),
        .i_we    (w_right_we),
        .i_waddr (w_right_wa),
        .i_wdata (w_right_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_right_rd)
    );

    btlpm_ram #(.WIDTH(MW), .DEPTH(NODES)) u_mark (
        .i_clk   (i_clk),
        .i_we    (w_mark_we),
        .i_waddr (w_mark_wa),
        .i_wdata (w_mark_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_mark_rd)
    );

endmodule

// File: design/binary_trie_longest_prefix_match.sv
// Top level of the IPv4 binary trie longest-prefix-match engine.
// One transaction at a time walks a one-bit-per-level trie held in three node
// memories (left child, right child, mark and port) that share one read address.
// A lookup visits the root plus up to 32 trie levels, between a start and a
// finish step. An insert walks each existing node on its path and allocates
// each new node through S_IN, S_ALLOC and S_LINK, then marks the last node;
// it too has a start and a finish step. The one-read-per-cycle node memory
// port sets the walk rate. After reset the engine empties the root before
// o_in_ready rises. A finished result waits in an output register; the next
// transaction is accepted meanwhile.
module binary_trie_longest_prefix_match
    import btlpm_pkg::*;
#(
    parameter int NODES      = 4096,
    parameter int PORT_WIDTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    btlpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    btlpm_dp #(.NODES(NODES), .PORT_WIDTH(PORT_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: design/btlpm_chk.sv
// Port-level checker for the trie engine, bound to the top level.
module btlpm_chk
    import btlpm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after input transaction");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> o_out_data.status == STATUS_OK)
        else $error("hit with error status");

    a_miss_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.port_out == '0)
        else $error("nonzero port on miss");

endmodule

bind binary_trie_longest_prefix_match btlpm_chk u_chk (.*);

// File: tb/tb.sv
// Testbench for the binary trie longest-prefix-match engine, checked against a trie predictor.
`timescale 1ns / 100ps

module tb;
    import btlpm_pkg::*;

    localparam int NODES       = 4096;
    localparam int NODE_W      = $clog2(NODES);
    localparam int ITEMS       = 750;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN       = 120;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam t_out NO_HIT  = '{1'b0, 8'h00, STATUS_OK};
    localparam t_out BAD_LEN = '{1'b0, 8'h00, STATUS_BADLEN};

    typedef struct packed {
        t_in  stim;
        bit   typed;
        t_out want;
    } t_dir_row;

    localparam int DIR_N = 25;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{'{FUNC_LOOKUP, 32'h0000_0000, 6'd0,  8'h00}, 1'b1, NO_HIT},
        '{'{FUNC_INSERT, 32'h1234_5678, 6'd0,  8'h77}, 1'b1, BAD_LEN},
        '{'{FUNC_INSERT, 32'h1234_5678, 6'd33, 8'h77}, 1'b1, BAD_LEN},
        '{'{FUNC_INSERT, 32'hFFFF_FFFF, 6'd63, 8'hFF}, 1'b1, BAD_LEN},
        '{'{FUNC_SPARE,  32'hFFFF_FFFF, 6'd63, 8'hFF}, 1'b1, NO_HIT},
        '{'{FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF}, 1'b1, NO_HIT},
        '{'{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00}, 1'b1, '{1'b1, 8'hFF, STATUS_OK}},
        '{'{FUNC_INSERT, 32'h0000_0000, 6'd32, 8'h00}, 1'b1, NO_HIT},
        '{'{FUNC_LOOKUP, 32'h0000_0000, 6'd32, 8'hFF}, 1'b1, '{1'b1, 8'h00, STATUS_OK}},
        // bits below the prefix are don't-care
        '{'{FUNC_INSERT, 32'h8FFF_FFFF, 6'd1,  8'h5A}, 1'b1, NO_HIT},
        '{'{FUNC_LOOKUP, 32'hC000_0000, 6'd0,  8'h00}, 1'b0, NO_HIT},
        '{'{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00}, 1'b0, NO_HIT},
        // reinsert overwrites the port
        '{'{FUNC_INSERT, 32'h8000_0000, 6'd1,  8'hA5}, 1'b1, NO_HIT},
        '{'{FUNC_LOOKUP, 32'h8000_0001, 6'd0,  8'h00}, 1'b0, NO_HIT},
        '{'{FUNC_LOOKUP, 32'h7FFF_FFFF, 6'd0,  8'h00}, 1'b0, NO_HIT},
        '{'{FUNC_INSERT, 32'hA500_0000, 6'd8,  8'h01}, 1'b1, NO_HIT},
        '{'{FUNC_INSERT, 32'hA5A5_A5A5, 6'd32, 8'h3C}, 1'b1, NO_HIT},
        '{'{FUNC_LOOKUP, 32'hA5A5_A5A5, 6'd0,  8'h00}, 1'b0, NO_HIT},
        '{'{FUNC_LOOKUP, 32'hA5FF_FFFF, 6'd0,  8'h00}, 1'b0, NO_HIT},
        '{'{FUNC_LOOKUP, 32'hA4FF_FFFF, 6'd0,  8'h00}, 1'b0, NO_HIT},
        '{'{FUNC_INSERT, 32'h0000_0001, 6'd31, 8'hC3}, 1'b1, NO_HIT},
        '{'{FUNC_LOOKUP, 32'h0000_0001, 6'd0,  8'h00}, 1'b0, NO_HIT},
        '{'{FUNC_CLEAR,  32'hFFFF_FFFF, 6'd63, 8'hFF}, 1'b1, NO_HIT},
        '{'{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00}, 1'b1, NO_HIT},
        '{'{FUNC_INSERT, 32'h4000_0000, 6'd2,  8'h99}, 1'b1, NO_HIT}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    bit [NODE_W-1:0] trie_left  [NODES];
    bit [NODE_W-1:0] trie_right [NODES];
    bit              trie_mark  [NODES];
    bit [PORT_W-1:0] trie_port  [NODES];
    int              free_ptr = 1;

    t_out              route_answers_q [$];
    logic [ADDR_W-1:0] known_prefixes  [$];
    int                n_mismatch = 0;
    int                n_results  = 0;
    int                n_sent     = 0;
    bit                calm       = 1'b0;
    bit                hold_req   = 1'b0;

    binary_trie_longest_prefix_match i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic t_out trie_predict(input t_in d);
        t_out r;
        int   cur;
        int   nxt;
        int   depth;
        bit   b;
        bit   stop;
        r    = NO_HIT;
        cur  = 0;
        stop = 1'b0;
        case (d.func)
            FUNC_CLEAR: begin
                free_ptr      = 1;
                trie_left[0]  = '0;
                trie_right[0] = '0;
                trie_mark[0]  = 1'b0;
            end
            FUNC_INSERT: begin
                if (d.prefix_len == 0 || d.prefix_len > MAX_LEN) begin
                    r.status = STATUS_BADLEN;
                end else begin
                    for (depth = 0; depth < d.prefix_len && !stop; depth++) begin
                        b   = d.address[ADDR_W-1-depth];
                        nxt = b ? trie_right[cur] : trie_left[cur];
                        if (nxt == 0) begin
                            if (free_ptr >= NODES) begin
                                r.status = STATUS_FULL;
                                stop     = 1'b1;
                            end else begin
                                nxt = free_ptr;
                                free_ptr++;
                                trie_left[nxt]  = '0;
                                trie_right[nxt] = '0;
                                trie_mark[nxt]  = 1'b0;
                                if (b) begin
                                    trie_right[cur] = NODE_W'(nxt);
                                end else begin
                                    trie_left[cur] = NODE_W'(nxt);
                                end
                            end
                        end
                        cur = nxt;
                    end
                    if (!stop) begin
                        trie_mark[cur] = 1'b1;
                        trie_port[cur] = d.port_in;
                    end
                end
            end
            FUNC_LOOKUP: begin
                depth = 0;
                while (!stop) begin
                    if (trie_mark[cur]) begin
                        r.found    = 1'b1;
                        r.port_out = trie_port[cur];
                    end
                    if (depth >= ADDR_W) begin
                        stop = 1'b1;
                    end else begin
                        cur  = d.address[ADDR_W-1-depth] ? trie_right[cur] : trie_left[cur];
                        depth++;
                        stop = (cur == 0);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in make_route_txn(input bit fill);
        t_in               d;
        int                r;
        int                k;
        logic [ADDR_W-1:0] mask;
        d.address    = $urandom;
        d.port_in    = PORT_W'($urandom);
        d.prefix_len = ($urandom_range(0, 4) == 0) ? MAX_LEN : LEN_W'($urandom_range(1, 32));
        r = $urandom_range(0, 99);
        if (fill) begin
            d.func = (r < 88) ? FUNC_INSERT : FUNC_LOOKUP;
            d.prefix_len = MAX_LEN;
        end else if (r < 3) begin
            d.func = FUNC_SPARE;
            d.prefix_len = LEN_W'($urandom);
        end else if (r < 5) begin
            d.func = FUNC_CLEAR;
        end else if (r < 50) begin
            d.func = FUNC_INSERT;
            k = $urandom_range(0, 99);
            if (k < 6) d.prefix_len = '0;
            else if (k < 14) d.prefix_len = LEN_W'($urandom_range(33, 63));
        end else begin
            d.func = FUNC_LOOKUP;
            d.prefix_len = LEN_W'($urandom);
        end
        // steer toward stored prefixes so walks go deep and lookups hit
        if (known_prefixes.size() > 0 &&
            $urandom_range(0, 99) < ((d.func == FUNC_LOOKUP) ? 75 : 40)) begin
            k    = $urandom_range(0, 32);
            mask = ADDR_W'((64'd1 << k) - 64'd1);
            d.address = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)]
                        ^ ($urandom & mask);
        end
        return d;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("ERROR: result %0d %s got %0h expected %0h", n_results, field, got, want);
        n_mismatch++;
    endtask

    task automatic apply_txn(input t_in d, input bit typed, input t_out want);
        int   gap;
        t_out pred;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge clk); while (!in_ready);
        pred = trie_predict(d);
        route_answers_q.push_back(typed ? want : pred);
        n_sent++;
        if (d.func == FUNC_CLEAR) begin
            known_prefixes.delete();
        end else if (d.func == FUNC_INSERT && d.prefix_len != 0 && d.prefix_len <= MAX_LEN) begin
            known_prefixes.push_back(d.address);
            if (known_prefixes.size() > 256) void'(known_prefixes.pop_front());
        end
    endtask

    initial begin : stimulus
        t_in d;
        int  sess;
        int  n;
        bit  fill;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIR_N; i++) begin
            apply_txn(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end
        for (sess = 0; n_sent < ITEMS; sess++) begin
            calm = (sess % 4 == 3);
            fill = (sess == 2);
            n    = fill ? 220 : $urandom_range(20, 60);
            if (fill || $urandom_range(0, 1) == 1) begin
                d = make_route_txn(1'b0);
                d.func = FUNC_CLEAR;
                apply_txn(d, 1'b0, NO_HIT);
            end
            for (int j = 0; j < n; j++) begin
                if (sess == 1 && j == 4) hold_req = 1'b1;
                apply_txn(make_route_txn(fill), 1'b0, NO_HIT);
            end
        end
        in_valid <= 1'b0;
        while (route_answers_q.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : receiver
        int stall;
        stall = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end else if (stall == 0 && $urandom_range(0, 99) < 30) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_routes
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (route_answers_q.size() == 0) begin
                flag_mismatch("unexpected transaction", 32'(out_data), '0);
            end else begin
                want = route_answers_q.pop_front();
                if (out_data.found !== want.found)
                    flag_mismatch("found", 32'(out_data.found), 32'(want.found));
                if (out_data.port_out !== want.port_out)
                    flag_mismatch("port_out", 32'(out_data.port_out), 32'(want.port_out));
                if (out_data.status !== want.status)
                    flag_mismatch("status", 32'(out_data.status), 32'(want.status));
            end
            n_results++;
        end
    end

    initial begin : watchdog
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
